### sv/dvc_pkg.sv
// Shared types and codes for the delta varint column decoder.
// No dependencies; used by every module of the block but dvc_fifo.
package dvc_pkg;

    localparam int IN_DEPTH_DEF  = 2;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_TRUNC    = 2'd2;

    // One classified byte, as queued between front and back.
    typedef struct packed {
        logic       flush;   // decoding disabled: only restart on end of buffer
        logic       eob;
        logic [7:0] data;
    } entry_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               valid;
        logic               done;
        logic [1:0]         err;
    } result_t;

endpackage

### sv/dvc_fifo.sv
// Small register-based FIFO used for the byte queue and the result queue.
// Generic; no package dependency.
module dvc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### sv/dvc_front.sv
// Front end: classifies incoming bytes and filters them into the byte queue.
// Depends on dvc_pkg.
module dvc_front (
    input  logic            push,
    input  logic [7:0]      byte_in,
    input  logic            end_of_buffer,
    input  logic            count_zero,
    output logic            q_push,
    output dvc_pkg::entry_t q_entry
);

    // With a zero expected count only the end-of-buffer byte matters (restart);
    // every other byte is consumed here and never reaches the back end.
    assign q_push        = push && (!count_zero || end_of_buffer);
    assign q_entry.flush = count_zero;
    assign q_entry.eob   = end_of_buffer;
    assign q_entry.data  = byte_in;

endmodule

### sv/dvc_back.sv
// Back end: header/varint/zigzag decode and running sum, one byte per cycle while the result queue has room.
// Depends on dvc_pkg.
module dvc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mode64,
    input  logic             q_empty,
    input  dvc_pkg::entry_t  q_entry,
    output logic             q_pop,
    input  logic             r_full,
    output logic             r_push,
    output dvc_pkg::result_t r_data
);

    localparam logic [2:0] PH_BASE  = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_DELTA = 3'd2;
    localparam logic [2:0] PH_DONE  = 3'd3;
    localparam logic [2:0] PH_ERROR = 3'd4;

    localparam logic [3:0] LIM32 = 4'd5;
    localparam logic [3:0] LIM64 = 4'd10;
    localparam logic [6:0] LOW7  = 7'h7F;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] run_reg, run_next;
    logic [31:0] rem_reg, rem_next;

    logic        go;
    logic        valid, done;
    logic [1:0]  err;
    logic [7:0]  b;
    logic        more;
    logic [3:0]  cnt_inc;
    logic [3:0]  lim;
    logic [6:0]  sh7;
    logic [63:0] acc_or;
    logic [63:0] d;
    logic [31:0] e32, d32;
    logic [63:0] shown;

    assign go    = !q_empty && !r_full;
    assign q_pop = go;
    assign b     = q_entry.data;
    assign more  = b[7];
    assign cnt_inc = cnt_reg + 1'b1;
    // 7 * count, valid while count < 10
    assign sh7   = {cnt_reg, 3'b000} - {3'b000, cnt_reg};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        run_next   = run_reg;
        rem_next   = rem_reg;
        valid      = 1'b0;
        done       = 1'b0;
        err        = dvc_pkg::ERR_NONE;
        lim        = LIM32;
        acc_or     = acc_reg;
        d          = '0;
        e32        = '0;
        d32        = '0;

        if (!q_entry.flush)
        begin
            unique case (phase_reg)
                PH_BASE:
                begin
                    if (!cnt_reg[3])
                    begin
                        acc_or = acc_reg | ({56'd0, b} << {cnt_reg[2:0], 3'b000});
                    end
                    acc_next = acc_or;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= (mode64 ? 4'd8 : 4'd4))
                    begin
                        run_next   = mode64 ? acc_or : {32'd0, acc_or[31:0]};
                        valid      = 1'b1;
                        phase_next = PH_COUNT;
                        cnt_next   = '0;
                        acc_next   = '0;
                    end
                end
                PH_COUNT, PH_DELTA:
                begin
                    lim = (phase_reg == PH_DELTA && mode64) ? LIM64 : LIM32;
                    if (cnt_reg < 4'd10)
                    begin
                        acc_or = acc_reg | ({57'd0, b[6:0] & LOW7} << sh7[5:0]);
                    end
                    acc_next = acc_or;
                    cnt_next = cnt_inc;
                    if (more)
                    begin
                        if (cnt_inc >= lim)
                        begin
                            err        = dvc_pkg::ERR_OVERFLOW;
                            phase_next = PH_ERROR;
                        end
                    end
                    else if (phase_reg == PH_COUNT)
                    begin
                        if (acc_or[31:0] == '0)
                        begin
                            done       = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            rem_next   = acc_or[31:0];
                            phase_next = PH_DELTA;
                        end
                        cnt_next = '0;
                        acc_next = '0;
                    end
                    else
                    begin
                        // zigzag decode, then wrapping add
                        if (mode64)
                        begin
                            d = (acc_or >> 1) ^ {64{acc_or[0]}};
                        end
                        else
                        begin
                            e32 = acc_or[31:0];
                            d32 = (e32 >> 1) ^ {32{e32[0]}};
                            d   = {{32{d32[31]}}, d32};
                        end
                        run_next = run_reg + d;
                        valid    = 1'b1;
                        rem_next = rem_reg - 1'b1;
                        if (rem_next == '0)
                        begin
                            done       = 1'b1;
                            phase_next = PH_DONE;
                        end
                        cnt_next = '0;
                        acc_next = '0;
                    end
                end
                default:
                begin
                    // done or error: skip bytes until end of buffer
                end
            endcase

            if (q_entry.eob && phase_next != PH_DONE && phase_next != PH_ERROR
                && err == dvc_pkg::ERR_NONE)
            begin
                err = dvc_pkg::ERR_TRUNC;
            end
        end

        shown = mode64 ? run_next : {{32{run_next[31]}}, run_next[31:0]};

        if (q_entry.eob)
        begin
            phase_next = PH_BASE;
            cnt_next   = '0;
            acc_next   = '0;
            run_next   = '0;
            rem_next   = '0;
        end
    end

    assign r_push       = go && !q_entry.flush && (valid || done || err != dvc_pkg::ERR_NONE);
    assign r_data.value = valid ? shown : 64'sd0;
    assign r_data.valid = valid;
    assign r_data.done  = done;
    assign r_data.err   = err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BASE;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            run_reg   <= '0;
            rem_reg   <= '0;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            run_reg   <= run_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

### sv/delta_varint_column_decoder.sv
// Delta varint column decoder: configuration registers, front, back and queues.
// Depends on dvc_pkg, dvc_fifo, dvc_front, dvc_back.
//
// Usage:
//   Bytes of a column buffer enter on byte_in/end_of_buffer through a queue
//   interface: a byte transfers when push is high and full is low.
//   Results leave through a queue interface: the oldest result is on
//   value_out/value_valid/column_done/error_code while empty is low, and it
//   transfers when pop is high and empty is low.
//   Registers: value_width_mode at byte address 0, expected_count at 4,
//   written through the APB port (pready tied high) while no byte is in flight.
//   Throughput: one byte per cycle while the result queue has room; one add per byte.
//   Path: a byte is registered in the byte queue, decoded combinationally by the
//   back end, and its result registered in the result queue, whose head drives
//   the result ports.
//   Bytes with no result still pass through the back end.
//   Stall: when pop stays low the result queue fills, the back end halts,
//   then the byte queue fills and full rises; nothing is dropped.
//   Reset: both queues empty, decoder at the start of a base header,
//   value_width_mode = 0, expected_count = 1.
module delta_varint_column_decoder #(
    parameter int IN_DEPTH  = dvc_pkg::IN_DEPTH_DEF,
    parameter int OUT_DEPTH = dvc_pkg::OUT_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         byte_in,
    input  logic               end_of_buffer,
    output logic               empty,
    input  logic               pop,
    output logic signed [63:0] value_out,
    output logic               value_valid,
    output logic               column_done,
    output logic [1:0]         error_code
);

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    logic        mode_reg;
    logic [31:0] count_reg;
    logic        wr_en;

    dvc_pkg::entry_t  fq_entry, bq_entry;
    dvc_pkg::result_t r_in, r_out;
    logic             fq_push, bq_empty, bq_pop;
    logic             r_push, r_full;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= 32'd1;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_MODE:  mode_reg  <= pwdata[0];
                REG_COUNT: count_reg <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MODE:  prdata = {31'd0, mode_reg};
            REG_COUNT: prdata = count_reg;
            default:   prdata = '0;
        endcase
    end

    dvc_front u_front (
        .push          (push),
        .byte_in       (byte_in),
        .end_of_buffer (end_of_buffer),
        .count_zero    (count_reg == '0),
        .q_push        (fq_push),
        .q_entry       (fq_entry)
    );

    dvc_fifo #(
        .WIDTH ($bits(dvc_pkg::entry_t)),
        .DEPTH (IN_DEPTH)
    ) u_byte_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata (fq_entry),
        .full  (full),
        .pop   (bq_pop),
        .rdata (bq_entry),
        .empty (bq_empty)
    );

    dvc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode64  (mode_reg),
        .q_empty (bq_empty),
        .q_entry (bq_entry),
        .q_pop   (bq_pop),
        .r_full  (r_full),
        .r_push  (r_push),
        .r_data  (r_in)
    );

    dvc_fifo #(
        .WIDTH ($bits(dvc_pkg::result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (r_push),
        .wdata (r_in),
        .full  (r_full),
        .pop   (pop),
        .rdata (r_out),
        .empty (empty)
    );

    assign value_out   = r_out.value;
    assign value_valid = r_out.valid;
    assign column_done = r_out.done;
    assign error_code  = r_out.err;

endmodule

### sv/dvc_checker.sv
// Port-level checks for the delta varint column decoder, bound to the top.
// Depends on dvc_pkg.
module dvc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic signed [63:0] value_out,
    input logic               value_valid,
    input logic               column_done,
    input logic [1:0]         error_code
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(value_out) && $stable(value_valid)
                           && $stable(column_done) && $stable(error_code))
        else $error("stalled result changed");

    a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !value_valid |-> value_out == 64'sd0)
        else $error("value_out nonzero without value_valid");

    a_meaningful: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (value_valid || column_done || error_code != dvc_pkg::ERR_NONE)
                   && !(column_done && error_code != dvc_pkg::ERR_NONE))
        else $error("empty result or done together with error");

endmodule

bind delta_varint_column_decoder dvc_checker u_dvc_checker (.*);

### bench/dvc_tb_pkg.sv
// Register map and decoded-value scoreboard for the column decoder bench.
// Depends on dvc_pkg (result_t, error codes).
package dvc_tb_pkg;

    localparam logic [2:0] ADDR_WIDTH_MODE     = 3'd0;
    localparam logic [2:0] ADDR_EXPECTED_COUNT = 3'd4;

    class column_scoreboard;
        typedef enum logic [2:0] {ST_BASE, ST_COUNT, ST_DELTA, ST_DONE, ST_ERROR} stage_t;

        bit                wide_mode;
        bit [31:0]         enabled_count;
        stage_t            stage;
        bit [3:0]          nbytes;
        bit [63:0]         acc;
        bit [63:0]         sum;
        bit [31:0]         left;
        dvc_pkg::result_t  decoded_q[$];
        int unsigned       mismatches;

        function new();
            wide_mode = 1'b0;
            enabled_count = 32'd1;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            stage = ST_BASE;
            nbytes = 4'd0;
            acc = 64'd0;
            sum = 64'd0;
            left = 32'd0;
        endfunction

        function void write_register(bit [2:0] addr, bit [31:0] data);
            if (addr == ADDR_WIDTH_MODE)
                wide_mode = data[0];
            else
                enabled_count = data;
        endfunction

        function bit [31:0] register_value(bit [2:0] addr);
            return (addr == ADDR_WIDTH_MODE) ? {31'd0, wide_mode} : enabled_count;
        endfunction

        function bit [63:0] shown_sum();
            if (wide_mode)
                return sum;
            return {{32{sum[31]}}, sum[31:0]};
        endfunction

        // Advance the decoder by one transferred byte; queue the result it causes, if any.
        function void decode_byte(bit [7:0] b, bit eob);
            bit               valid;
            bit               done;
            bit [1:0]         err;
            bit [3:0]         limit;
            bit [31:0]        d32;
            bit [63:0]        d;
            dvc_pkg::result_t r;
            valid = 1'b0;
            done = 1'b0;
            err = dvc_pkg::ERR_NONE;
            if (enabled_count == 0)
            begin
                if (eob)
                    restart();
                return;
            end
            case (stage)
                ST_BASE:
                begin
                    if (nbytes < 4'd8)
                        acc |= {56'd0, b} << (8 * nbytes);
                    nbytes++;
                    if (nbytes >= (wide_mode ? 4'd8 : 4'd4))
                    begin
                        sum = wide_mode ? acc : {32'd0, acc[31:0]};
                        valid = 1'b1;
                        stage = ST_COUNT;
                        nbytes = 4'd0;
                        acc = 64'd0;
                    end
                end
                ST_COUNT, ST_DELTA:
                begin
                    limit = (stage == ST_DELTA && wide_mode) ? 4'd10 : 4'd5;
                    if (nbytes < 4'd10)
                        acc |= {57'd0, b[6:0]} << (7 * nbytes);
                    nbytes++;
                    if (b[7])
                    begin
                        if (nbytes >= limit)
                        begin
                            err = dvc_pkg::ERR_OVERFLOW;
                            stage = ST_ERROR;
                        end
                    end
                    else if (stage == ST_COUNT)
                    begin
                        if (acc[31:0] == 32'd0)
                        begin
                            done = 1'b1;
                            stage = ST_DONE;
                        end
                        else
                        begin
                            left = acc[31:0];
                            stage = ST_DELTA;
                        end
                        nbytes = 4'd0;
                        acc = 64'd0;
                    end
                    else
                    begin
                        // zigzag back to signed; narrow deltas sign-extend before the add
                        if (wide_mode)
                        begin
                            d = (acc >> 1) ^ {64{acc[0]}};
                        end
                        else
                        begin
                            d32 = (acc[31:0] >> 1) ^ {32{acc[0]}};
                            d = {{32{d32[31]}}, d32};
                        end
                        sum += d;
                        valid = 1'b1;
                        left--;
                        if (left == 32'd0)
                        begin
                            done = 1'b1;
                            stage = ST_DONE;
                        end
                        nbytes = 4'd0;
                        acc = 64'd0;
                    end
                end
                default: ;
            endcase
            if (eob && stage != ST_DONE && stage != ST_ERROR && err == dvc_pkg::ERR_NONE)
                err = dvc_pkg::ERR_TRUNC;
            if (valid || done || err != dvc_pkg::ERR_NONE)
            begin
                r.value = valid ? shown_sum() : 64'd0;
                r.valid = valid;
                r.done = done;
                r.err = err;
                decoded_q.insert(decoded_q.size(), r);
            end
            if (eob)
                restart();
        endfunction

        function void check_decoded(dvc_pkg::result_t got);
            dvc_pkg::result_t want;
            if (decoded_q.size() == 0)
            begin
                $error({"unexpected result: value_out %h value_valid %b",
                        " column_done %b error_code %0d"},
                       got.value, got.valid, got.done, got.err);
                mismatches++;
                return;
            end
            want = decoded_q.pop_front();
            if (got.value !== want.value)
            begin
                $error("value_out: expected %h, got %h", want.value, got.value);
                mismatches++;
            end
            if (got.valid !== want.valid)
            begin
                $error("value_valid: expected %b, got %b", want.valid, got.valid);
                mismatches++;
            end
            if (got.done !== want.done)
            begin
                $error("column_done: expected %b, got %b", want.done, got.done);
                mismatches++;
            end
            if (got.err !== want.err)
            begin
                $error("error_code: expected %0d, got %0d", want.err, got.err);
                mismatches++;
            end
        endfunction
    endclass

endpackage

### bench/tb_top.sv
// Top-level bench for delta_varint_column_decoder: byte driver, result popper, APB writes and reads.
// Depends on dvc_pkg, dvc_tb_pkg and the decoder RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 80;
    localparam int NUM_PHASES     = 7;
    localparam int PRESSURE_PHASE = 3;
    localparam int RANDOM_PHASE   = 5;
    localparam int PHASE_BYTES    = 125;
    localparam int IGNORED_BYTES  = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       eob;
    } stim_t;

    logic               clk;
    logic               rst_n = 1'b1;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         byte_in = '0;
    logic               end_of_buffer = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [63:0] value_out;
    logic               value_valid;
    logic               column_done;
    logic [1:0]         error_code;

    dvc_tb_pkg::column_scoreboard sb = new();
    stim_t            plan[$];
    int unsigned      phase_bytes;
    int unsigned      send_idle_pct = 0;
    int unsigned      stall_pct = 0;
    int unsigned      hold_left = 0;

    bit          ph_wide [NUM_PHASES]      = '{0, 1, 0, 0, 1, 1, 0};
    bit [31:0]   ph_count [NUM_PHASES]     = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd7, 32'd1,
                                               32'd1, 32'hFFFF_FFFF};
    int unsigned ph_send_idle [NUM_PHASES] = '{0, 74, 34, 0, 34, 0, 0};
    int unsigned ph_stall [NUM_PHASES]     = '{0, 0, 34, 74, 34, 0, 74};

    delta_varint_column_decoder i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side: random stalls, plus one long hold-off to back up the input
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
            begin
                pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_decoded('{value_out, value_valid, column_done, error_code});
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void add_byte(input logic [7:0] b, input logic eob = 1'b0);
        stim_t s;
        s.data = b;
        s.eob = eob;
        plan.insert(plan.size(), s);
    endfunction

    function automatic bit [63:0] pick_value(input bit wide_field);
        bit [63:0] v;
        case ($urandom_range(3))
            0: v = {$urandom(), $urandom()};
            1:
            begin
                v = 64'($urandom_range(200));
                v = v - 64'd100;
            end
            2:
            begin
                case ($urandom_range(3))
                    0: v = wide_field ? 64'h8000_0000_0000_0000 : 64'hFFFF_FFFF_8000_0000;
                    1: v = wide_field ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
                    2: v = 64'd0;
                    default: v = '1;
                endcase
            end
            default:
            begin
                v = {$urandom(), $urandom()} >> $urandom_range(63);
                if ($urandom_range(1) == 1)
                    v = -v;
            end
        endcase
        if (!wide_field)
            v = {{32{v[31]}}, v[31:0]};
        return v;
    endfunction

    function automatic bit [63:0] zigzag(input bit [63:0] v, input bit wide_field);
        bit [31:0] z32;
        if (wide_field)
            return (v << 1) ^ {64{v[63]}};
        z32 = (v[31:0] << 1) ^ {32{v[31]}};
        return {32'd0, z32};
    endfunction

    function automatic void add_varint(input bit [63:0] v, input int lim);
        bit [63:0] rest;
        bit [7:0]  b;
        int        total;
        total = 1;
        rest = v >> 7;
        while (rest != 0)
        begin
            total++;
            rest = rest >> 7;
        end
        // sometimes the padded, non-minimal encoding
        if ($urandom_range(7) == 0)
            total = $urandom_range(lim, total);
        rest = v;
        for (int i = 0; i < total; i++)
        begin
            b = {1'b0, rest[6:0]};
            rest = rest >> 7;
            if (i < total - 1)
                b[7] = 1'b1;
            else if (i == lim - 1 && $urandom_range(2) == 0)
                b[6:0] = b[6:0] | ((lim == 10 ? 7'h7E : 7'h70) & 7'($urandom()));
            add_byte(b);
        end
    endfunction

    function automatic void plan_buffer();
        int        kind;
        int        start;
        int        cut;
        int        lim;
        bit [31:0] n;
        bit [31:0] ndelta;
        bit [63:0] base;
        kind = $urandom_range(99);
        start = plan.size();
        if (kind < 90 || $urandom_range(1) == 1)
        begin
            base = pick_value(sb.wide_mode);
            for (int i = 0; i < (sb.wide_mode ? 8 : 4); i++)
                add_byte(base[8*i +: 8]);
        end
        if (kind < 80)
        begin
            if (kind >= 60 && $urandom_range(2) == 0)
                n = $urandom();
            else
                n = $urandom_range(5);
            ndelta = (n > 6) ? $urandom_range(3) : n;
            add_varint(64'(n), 5);
            repeat (ndelta)
                add_varint(zigzag(pick_value(sb.wide_mode), sb.wide_mode),
                           sb.wide_mode ? 10 : 5);
            if (kind < 60)
            begin
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
            end
            else
            begin
                // end of buffer lands anywhere, inside the header too
                cut = $urandom_range(start, plan.size() - 1);
                while (plan.size() > cut + 1)
                    void'(plan.pop_back());
            end
        end
        else if (kind < 90)
        begin
            lim = 5;
            if ($urandom_range(1) == 1)
            begin
                n = $urandom_range(1, 3);
                add_varint(64'(n), 5);
                repeat ($urandom_range(n - 1))
                    add_varint(zigzag(pick_value(sb.wide_mode), sb.wide_mode),
                               sb.wide_mode ? 10 : 5);
                lim = sb.wide_mode ? 10 : 5;
            end
            repeat (lim) add_byte(8'h80 | 8'($urandom_range(127)));
            repeat ($urandom_range(2)) add_byte(8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(1, 10))
                add_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
        end
        plan[plan.size() - 1].eob = 1'b1;
    endfunction

    task automatic send_byte(input stim_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        byte_in <= s.data;
        end_of_buffer <= s.eob;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.decode_byte(s.data, s.eob);
        if (sb.enabled_count != 0)
            phase_bytes++;
        @(negedge clk);
    endtask

    task automatic send_plan();
        foreach (plan[i])
            send_byte(plan[i]);
        plan.delete();
    endtask

    // wait until every expected result has transferred and the pipeline is quiet
    task automatic drain();
        push <= 1'b0;
        while (sb.decoded_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_register(addr, data);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic reg_read_check(input logic [2:0] addr);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== sb.register_value(addr))
        begin
            $error("prdata at %0d: expected %h, got %h",
                   addr, sb.register_value(addr), prdata);
            sb.mismatches++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        bit [31:0] count;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 0)
            begin
                reg_read_check(dvc_tb_pkg::ADDR_WIDTH_MODE);
                reg_read_check(dvc_tb_pkg::ADDR_EXPECTED_COUNT);
                // largest positive base; +1 wraps to the most negative 32-bit value
                add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'h7F);
                add_byte(8'h01); add_byte(8'h02, 1'b1);
                // negative base, zero delta count, bytes after completion ignored
                add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(8'h80);
                add_byte(8'h00); add_byte(8'hAA); add_byte(8'h55, 1'b1);
                // short header
                add_byte(8'h01); add_byte(8'h02, 1'b1);
                // buffer ends on a completed delta with one still owed
                add_byte(8'h10); add_byte(8'h20); add_byte(8'h30); add_byte(8'h40);
                add_byte(8'h02); add_byte(8'h03, 1'b1);
                send_plan();
            end
            else
            begin
                drain();
                count = (p == RANDOM_PHASE) ? ($urandom() | 32'd1) : ph_count[p];
                reg_write(dvc_tb_pkg::ADDR_WIDTH_MODE, {31'd0, ph_wide[p]});
                reg_read_check(dvc_tb_pkg::ADDR_WIDTH_MODE);
                reg_write(dvc_tb_pkg::ADDR_EXPECTED_COUNT, count);
                reg_read_check(dvc_tb_pkg::ADDR_EXPECTED_COUNT);
            end
            send_idle_pct = ph_send_idle[p];
            stall_pct = ph_stall[p];
            if (p == PRESSURE_PHASE)
                hold_left = HOLD_CYCLES;
            if (sb.enabled_count == 0)
            begin
                repeat (IGNORED_BYTES)
                    add_byte(8'($urandom_range(255)), $urandom_range(6) == 0);
                send_plan();
            end
            else
            begin
                phase_bytes = 0;
                while (phase_bytes < PHASE_BYTES)
                begin
                    plan_buffer();
                    send_plan();
                end
                // leave a buffer open so the next setting applies mid-stream
                if ($urandom_range(1) == 1)
                begin
                    plan_buffer();
                    plan[plan.size() - 1].eob = 1'b0;
                    send_plan();
                end
            end
        end
        stall_pct = 0;
        drain();
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
